FILE: rtl/core/f8c_pkg.sv
// Shared types, constants and conversion helpers for the FP8/FP32 converter.
package f8c_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned AddrWidth = 3;

   localparam logic [AddrWidth-1:0] RegFormat    = 3'd0;
   localparam logic [AddrWidth-1:0] RegDirection = 3'd4;

   localparam logic [30:0] E4m3MaxBits = 31'h43E00000;
   localparam logic [30:0] E5m2MaxBits = 31'h47600000;
   localparam logic [6:0]  E4m3MaxCode = 7'h7E;
   localparam logic [6:0]  E5m2MaxCode = 7'h7B;

   typedef struct packed {
      logic fmt;   // 1 = E5M2
      logic dir;   // 1 = encode
   } mode_type;

   // Stage 1 -> stage 2 payload for the encode path.
   typedef struct packed {
      logic        sign;
      logic        sat;
      logic        zero;
      logic [23:0] sig;
      logic [4:0]  sh;     // right shift, 20..31 or beyond (flagged by zero)
      logic [4:0]  ecode;  // biased exponent base (t + bias - 1)
   } enc_type;

   // Exact decode of an FP8 code into an FP32 pattern.
   function automatic logic [31:0] decode_fp8(input logic [7:0] code, input logic fmt);
      logic [6:0]  mag;
      logic [4:0]  e;
      logic [2:0]  f;
      logic [7:0]  fe;
      logic [22:0] frac;
      logic [31:0] out;
      mag  = code[6:0];
      e    = fmt ? mag[6:2] : {1'b0, mag[6:3]};
      f    = fmt ? {1'b0, mag[1:0]} : mag[2:0];
      fe   = '0;
      frac = '0;
      if (e != 5'd0) begin
         fe   = 8'(e) + (fmt ? 8'd112 : 8'd120);
         frac = fmt ? {f[1:0], 21'd0} : {f, 20'd0};
      end else if (f != 3'd0) begin
         // Subnormal: normalise on the leading set bit of the fraction.
         if (f[2]) begin
            fe   = 8'd120;
            frac = {f[1:0], 21'd0};
         end else if (f[1]) begin
            fe   = fmt ? 8'd112 : 8'd119;
            frac = {f[0], 22'd0};
         end else begin
            fe   = fmt ? 8'd111 : 8'd118;
            frac = '0;
         end
      end
      out = {code[7], fe, frac};
      return out;
   endfunction

endpackage

FILE: rtl/core/f8c_stream_if.sv
// Valid/ready stream interface carrying one 32-bit word.
interface f8c_stream_if;
   logic        valid;
   logic        ready;
   logic [31:0] bits;
   modport source (output valid, output bits, input ready);
   modport sink   (input valid, input bits, output ready);
endinterface

FILE: rtl/core/fp8_fp32_converter.sv
// Top level of the FP8 <-> FP32 converter: three-stage pipeline.
//
//  channel | direction | handshake          | payload
//  req     | in        | valid/ready        | value_bits [31:0]
//  rsp     | out       | valid/ready        | result_bits [31:0]
//  csr     | in        | APB write/read     | format_select, direction
//
// One word per cycle sustained while the output is not stalled; the stages are
// classify, round and pack. Each stage holds its word while the next is full and stalled;
// a stage advances when it is empty or its successor takes its word.
// Reset is synchronous and clears only the valid bits and the configuration registers.
module fp8_fp32_converter (
   input  logic                          clock,
   input  logic                          reset,
   f8c_stream_if.sink                    req,
   f8c_stream_if.source                  rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [f8c_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import f8c_pkg::*;

   mode_type mode;

   f8c_regs u_regs (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .mode
   );

   // Valid bits of the three stages; advance signals.
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;
   assign adv3 = !v3_ff || rsp.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req.ready = adv1;

   // Stage 1: classify the word.
   logic        dir1_ff;
   logic [31:0] dec1_ff;
   enc_type     enc1_ff, enc1_in;

   always_comb begin
      logic [30:0] a;
      logic [30:0] mx;
      logic [7:0]  ebits;
      logic [8:0]  tb;   // t + 127
      logic [8:0]  lim;
      logic [9:0]  shw;
      a     = req.bits[30:0];
      ebits = a[30:23];
      mx    = mode.fmt ? E5m2MaxBits : E4m3MaxBits;
      lim   = mode.fmt ? 9'd113 : 9'd121;   // 1 - bias + 127
      tb    = ({1'b0, ebits} > lim) ? {1'b0, ebits} : lim;
      // sh = 23 + t - e - mbits
      shw   = 10'(tb) + 10'd23 - 10'(ebits) - (mode.fmt ? 10'd2 : 10'd3);
      enc1_in.sign  = req.bits[31];
      enc1_in.sat   = a > mx;
      enc1_in.zero  = (ebits == 8'd0) || (shw > 10'd31);
      enc1_in.sig   = {1'b1, a[22:0]};
      enc1_in.sh    = shw[4:0];
      enc1_in.ecode = 5'(tb - 9'd127 + (mode.fmt ? 9'd14 : 9'd6));
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv1) v1_ff <= req.valid;
      if (adv1 && req.valid) begin
         dir1_ff <= mode.dir;
         dec1_ff <= decode_fp8(req.bits[7:0], mode.fmt);
         enc1_ff <= enc1_in;
      end
   end

   // Stage 2: shift and round to nearest even.
   logic        dir2_ff, fmt2_ff, sign2_ff, sat2_ff, zero2_ff;
   logic [31:0] dec2_ff;
   logic [4:0]  ecode2_ff;
   logic [23:0] rnd2_ff, rnd2_in;
   logic        fmt1_ff;

   always_ff @(posedge clock) begin
      if (adv1 && req.valid) fmt1_ff <= mode.fmt;
   end

   // Keep the remainder and the half point at full width: for large shifts
   // the half point lies above every 24-bit significand.
   always_comb begin
      logic [23:0] lower;
      logic [31:0] rem, half, mask;
      lower   = enc1_ff.sig >> enc1_ff.sh;
      mask    = (32'd1 << enc1_ff.sh) - 32'd1;
      rem     = {8'd0, enc1_ff.sig} & mask;
      half    = 32'd1 << (enc1_ff.sh - 5'd1);
      rnd2_in = lower;
      if (rem > half || (rem == half && lower[0])) rnd2_in = lower + 24'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv2) v2_ff <= v1_ff;
      if (adv2 && v1_ff) begin
         dir2_ff   <= dir1_ff;
         fmt2_ff   <= fmt1_ff;
         dec2_ff   <= dec1_ff;
         sign2_ff  <= enc1_ff.sign;
         sat2_ff   <= enc1_ff.sat;
         zero2_ff  <= enc1_ff.zero;
         ecode2_ff <= enc1_ff.ecode;
         rnd2_ff   <= rnd2_in;
      end
   end

   // Stage 3: pack the code and pick the direction.
   logic [31:0] out3_ff, out3_in;
   always_comb begin
      logic [6:0] code;
      if (sat2_ff)       code = fmt2_ff ? E5m2MaxCode : E4m3MaxCode;
      else if (zero2_ff) code = '0;
      else               code = fmt2_ff ? 7'({ecode2_ff, 2'b00} + 7'(rnd2_ff))
                                        : 7'({ecode2_ff[3:0], 3'b000} + 7'(rnd2_ff));
      out3_in = dir2_ff ? {24'd0, sign2_ff, code} : dec2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv3) v3_ff <= v2_ff;
      if (adv3 && v2_ff) out3_ff <= out3_in;
   end

   assign rsp.valid = v3_ff;
   assign rsp.bits  = out3_ff;

   // A word held at the output must not change while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp.ready |=> v3_ff && $stable(out3_ff)) else $error("output lost");
   // A full stage behind a stalled full stage stays full.
   a_v2: assert property (@(posedge clock) disable iff (reset)
      v2_ff && v3_ff && !rsp.ready |=> v2_ff) else $error("stage 2 dropped");
   // Encode results keep bits 31..8 clear.
   a_enc: assert property (@(posedge clock) disable iff (reset)
      v3_ff && $past(adv3) && $past(v2_ff) && $past(dir2_ff) |-> out3_ff[31:8] == 24'd0)
      else $error("encode upper bits");
endmodule

FILE: rtl/core/f8c_regs.sv
// Configuration register file behind the APB-style port.
module f8c_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [f8c_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output f8c_pkg::mode_type           mode
);
   import f8c_pkg::*;
   logic fmt_ff, dir_ff, wr;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
         dir_ff <= 1'b0;
      end else if (wr) begin
         if (csr_paddr == RegFormat) fmt_ff <= csr_pwdata[0];
         if (csr_paddr == RegDirection) dir_ff <= csr_pwdata[0];
      end
   end
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == RegFormat) csr_prdata[0] = fmt_ff;
      else if (csr_paddr == RegDirection) csr_prdata[0] = dir_ff;
   end
   assign mode.fmt = fmt_ff;
   assign mode.dir = dir_ff;
endmodule

FILE: bench/fp8_fp32_converter_tb.sv
// Self-checking bench for the FP8/FP32 converter: directed and random words in both directions.
`timescale 1ns / 1ps
module fp8_fp32_converter_tb;
   import f8c_pkg::*;

   logic clock;
   logic reset;

   f8c_stream_if req ();
   f8c_stream_if rsp ();

   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   fp8_fp32_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Conversion mode as the bench believes it to be.
   logic fmt_e5m2;
   logic dir_encode;

   logic [31:0] pending_words[$];   // words waiting to be sent
   logic [31:0] expected_words[$];  // converted words awaiting the output
   int          mismatches = 0;
   bit          calm = 0;           // suppress random idling
   bit          hold_sender = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Append a word to the send queue.
   function automatic void queue_word(input logic [31:0] w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // Decode an FP8 code to an FP32 pattern, working on the fields directly.
   function automatic logic [31:0] fp8_to_fp32(input logic [7:0] code, input logic e5);
      int          mb;
      int          bias;
      logic [6:0]  mag;
      int          ex;
      int          fr;
      int          p;
      logic [31:0] w;
      mb   = e5 ? 2 : 3;
      bias = e5 ? 15 : 7;
      mag  = code[6:0];
      ex   = mag >> mb;
      fr   = mag & ((1 << mb) - 1);
      w    = {code[7], 31'd0};
      if (ex != 0) begin
         w[30:23] = 8'(ex - bias + 127);
         w[22:0]  = 23'(fr << (23 - mb));
      end else if (fr != 0) begin
         p = 0;
         while (p < mb - 1 && (fr >> (p + 1)) != 0) p++;
         w[30:23] = 8'(p + 1 - bias - mb + 127);
         w[22:0]  = 23'((fr - (1 << p)) << (23 - p));
      end
      return w;
   endfunction

   // Encode an FP32 pattern to FP8 with clamping and round-to-nearest-even.
   function automatic logic [7:0] fp32_to_fp8(input logic [31:0] x, input logic e5);
      int          mb;
      int          bias;
      logic [30:0] a;
      int          ex;
      int          t;
      int          sh;
      logic [31:0] sig;
      logic [31:0] lower;
      logic [31:0] rem;
      logic [31:0] half;
      logic [6:0]  code;
      mb   = e5 ? 2 : 3;
      bias = e5 ? 15 : 7;
      a    = x[30:0];
      if (a > (e5 ? E5m2MaxBits : E4m3MaxBits)) begin
         code = e5 ? E5m2MaxCode : E4m3MaxCode;
      end else if (a[30:23] == 0) begin
         code = '0;
      end else begin
         ex  = int'(a[30:23]) - 127;
         sig = {9'd1, a[22:0]};
         t   = (ex > 1 - bias) ? ex : 1 - bias;
         sh  = 23 + t - ex - mb;
         lower = 0;
         if (sh <= 31) begin
            lower = sig >> sh;
            rem   = sig & ((32'd1 << sh) - 1);
            half  = 32'd1 << (sh - 1);
            if (rem > half || (rem == half && lower[0])) lower++;
         end
         code = 7'(((t + bias - 1) << mb) + lower);
      end
      return {x[31], code};
   endfunction

   // Driver: advance to the next word once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.bits  <= '0;
      end else if (!req.valid || req.ready) begin
         if (pending_words.size() > 0 && !hold_sender
             && (calm || $urandom_range(99) >= 38)) begin
            req.bits  <= pending_words[0];
            req.valid <= 1'b1;
            expected_words.insert(expected_words.size(), dir_encode ?
               {24'd0, fp32_to_fp8(pending_words[0], fmt_e5m2)} :
               fp8_to_fp32(pending_words[0][7:0], fmt_e5m2));
            void'(pending_words.pop_front());
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted word against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp.bits);
               mismatches++;
            end else begin
               if (rsp.bits !== expected_words[0]) begin
                  $display("%0t: result_bits expected %h, actual %h",
                           $time, expected_words[0], rsp.bits);
                  mismatches++;
               end
               void'(expected_words.pop_front());
            end
         end
         rsp.ready <= calm || $urandom_range(99) >= 38;
      end
   end

   task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {$urandom} & ~32'd1 | 32'(val);   // only the low bit counts
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drain everything in flight, then switch mode.
   task automatic set_mode(input logic e5, input logic enc);
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req.valid || expected_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      write_reg(RegFormat, e5);
      write_reg(RegDirection, enc);
      fmt_e5m2   = e5;
      dir_encode = enc;
   endtask

   // Random FP32 words biased towards the interesting exponent range.
   function automatic logic [31:0] random_fp32();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: w[30:23] = 8'($urandom_range(100, 145));
         5: w[30:23] = 8'($urandom_range(140, 143));
         6: w[30:23] = 8'hFF;
         7: w[30:23] = 8'h00;
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      int k;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      fmt_e5m2    = 1'b0;
      dir_encode  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed decode: zero, negative zero, top codes, subnormals, junk upper bits.
      for (int f = 0; f < 2; f++) begin
         set_mode(f[0], 1'b0);
         queue_word(32'h00);
         queue_word(32'h80);
         queue_word(32'h7F);
         queue_word(32'hFFFFFFFF);
         queue_word(32'hABCDEF01);
         queue_word(32'h02);
         queue_word(32'h05);
      end
      // Directed encode: signed zero, max, overflow, infinity, NaN, subnormal, ties.
      for (int f = 0; f < 2; f++) begin
         set_mode(f[0], 1'b1);
         queue_word(32'h00000000);
         queue_word(32'h80000000);
         queue_word(32'h43E00000);
         queue_word(32'hC7600000);
         queue_word(32'h7F800000);
         queue_word(32'hFFC00001);
         queue_word(32'h00000001);
         queue_word(32'h3B000000);
         queue_word(32'h3F880000);
         queue_word(32'h7F7FFFFF);
      end

      // Random phases through every mode; the first decode phase runs without idling.
      for (int ph = 0; ph < 8; ph++) begin
         set_mode(ph[0], ph[1]);
         calm = (ph == 0);
         k = 100;
         for (int i = 0; i < k; i++) begin
            queue_word(ph[1] ? random_fp32() : 32'($urandom));
            // Hold the sender once until the pipeline is empty.
            if (ph == 3 && i == 50) begin
               wait (pending_words.size() == 0);
               hold_sender = 1;
               @(posedge clock);
               while (req.valid || expected_words.size() != 0) @(posedge clock);
               hold_sender = 0;
            end
         end
      end
      calm = 0;
      set_mode(1'b0, 1'b0);   // drains the last phase and leaves reset mode behind

      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/f8c_pkg.sv
rtl/core/f8c_stream_if.sv
rtl/core/f8c_regs.sv
rtl/core/fp8_fp32_converter.sv
bench/fp8_fp32_converter_tb.sv
